// ----- sv/abta_pkg.sv -----
// Shared types and constants for the ADC block averaging and threshold block.
package abta_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int SENSORS    = 4;
   localparam int THR_W      = 13;
   localparam int MV_W       = 14;
   localparam int REPORT_CH  = 5;
   localparam int BAT_CH     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Battery scaling: 3300 mV full scale times the (100 + 33) / 33 divider.
   localparam int BAT_SCALE_MV = 13300;
   localparam int BAT_PROD_W   = 26;
   localparam int BAT_SHIFT    = 38;
   localparam int BAT_RECIP_W  = 27;
   localparam int BAT_FULL_W   = BAT_PROD_W + BAT_RECIP_W;
   // Rounded-up reciprocal of the 4095 full-scale code, exact for 26-bit products.
   localparam logic [BAT_RECIP_W-1:0] BAT_RECIP =
      BAT_RECIP_W'(((64'd1 << BAT_SHIFT) + 64'd4094) / 64'd4095);

   localparam logic [CSR_IDX_W-1:0] CSR_SEEING_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_ENABLE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BATTERY_MV   = 2'd2;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET   = 13'd1000;
   localparam logic [SENSORS-1:0] ENABLE_RESET      = 4'hF;
   localparam logic [MV_W-1:0]    LOW_BAT_MV_RESET  = 14'd11250;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [SENSORS-1:0] enable;
      logic [MV_W-1:0]    low_mv;
   } cfg_type;

   typedef logic [REPORT_CH-1:0][SAMPLE_W-1:0] avg_set_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_left_side;
      logic [SAMPLE_W-1:0] avg_left_front;
      logic [SAMPLE_W-1:0] avg_right_front;
      logic [SAMPLE_W-1:0] avg_right_side;
      logic [SENSORS-1:0]  seeing_mask;
      logic [MV_W-1:0]     battery_mv;
      logic                low_battery;
   } rsp_type;

endpackage

// ----- sv/abta_if.sv -----
// Channel interfaces: sample input, result output and register write port.
interface abta_req_if import abta_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface abta_rsp_if import abta_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] avg_left_side;
   logic [SAMPLE_W-1:0] avg_left_front;
   logic [SAMPLE_W-1:0] avg_right_front;
   logic [SAMPLE_W-1:0] avg_right_side;
   logic [SENSORS-1:0]  seeing_mask;
   logic [MV_W-1:0]     battery_mv;
   logic                low_battery;

   modport source (output valid, output avg_left_side, output avg_left_front,
                   output avg_right_front, output avg_right_side, output seeing_mask,
                   output battery_mv, output low_battery, input ready);
   modport sink (input valid, input avg_left_side, input avg_left_front,
                 input avg_right_front, input avg_right_side, input seeing_mask,
                 input battery_mv, input low_battery, output ready);
endinterface

interface abta_csr_if import abta_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink (input valid, input reg_index, input data, output ready);
endinterface

// ----- sv/abta_accum.sv -----
// Per-channel sample accumulation with channel and round tracking.
module abta_accum import abta_pkg::*; #(
   parameter int CHANNELS = 5,
   parameter int ROUNDS = 16,
   localparam int SUM_W = SAMPLE_W + $clog2(ROUNDS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   output logic                blk_valid,
   input  logic                blk_ready,
   output logic [SUM_W-1:0]    blk_sums [REPORT_CH]
);

   localparam int POS_W = $clog2(CHANNELS);
   localparam int RND_W = $clog2(ROUNDS + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [RND_W-1:0] round_ff, round_in;
   logic [SUM_W-1:0] sums_ff [REPORT_CH];
   logic [SUM_W-1:0] sums_in [REPORT_CH];
   logic [SUM_W-1:0] total [REPORT_CH];
   logic [SUM_W-1:0] blk_sums_ff [REPORT_CH];
   logic             blk_valid_ff, blk_valid_in;
   logic             last_pos, last_round, block_end, take;

   assign last_pos   = pos_ff == POS_W'(CHANNELS - 1);
   assign last_round = round_ff == RND_W'(ROUNDS - 1);
   assign block_end  = last_pos && last_round;
   // Only the closing sample of a block needs room in the block register.
   assign in_ready   = !block_end || !blk_valid_ff || blk_ready;
   assign take       = in_valid && in_ready;

   always_comb begin
      for (int c = 0; c < REPORT_CH; c++) begin
         total[c] = sums_ff[c] + ((pos_ff == POS_W'(c)) ? SUM_W'(in_sample) : '0);
      end
      pos_in       = pos_ff;
      round_in     = round_ff;
      sums_in      = sums_ff;
      blk_valid_in = blk_valid_ff && !blk_ready;
      if (take) begin
         if (last_pos) begin
            pos_in   = '0;
            round_in = last_round ? '0 : round_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         for (int c = 0; c < REPORT_CH; c++) begin
            sums_in[c] = block_end ? '0 : total[c];
         end
         if (block_end) begin
            blk_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         round_ff     <= '0;
         blk_valid_ff <= 1'b0;
         for (int c = 0; c < REPORT_CH; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         blk_valid_ff <= blk_valid_in;
         sums_ff      <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && block_end) begin
         blk_sums_ff <= total;
      end
   end

   assign blk_valid = blk_valid_ff;
   assign blk_sums  = blk_sums_ff;

endmodule

// ----- sv/abta_average.sv -----
// Block averages by multiplication with the rounded-up reciprocal of the round count.
module abta_average import abta_pkg::*; #(
   parameter int ROUNDS = 16,
   localparam int SUM_W = SAMPLE_W + $clog2(ROUNDS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             blk_valid,
   output logic             blk_ready,
   input  logic [SUM_W-1:0] blk_sums [REPORT_CH],
   output logic             avg_valid,
   input  logic             avg_ready,
   output avg_set_type      avgs
);

   localparam int LOG_R   = $clog2(ROUNDS);
   localparam int SHIFT   = SUM_W + LOG_R;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(ROUNDS) - 64'd1) / 64'(ROUNDS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   logic [PROD_W-1:0] prod [REPORT_CH];
   avg_set_type       avgs_ff, avgs_in;
   logic              avg_valid_ff;
   logic              take;

   assign blk_ready = !avg_valid_ff || avg_ready;
   assign take      = blk_valid && blk_ready;

   // The quotient is exact because the shift covers the sum width plus the divisor width.
   always_comb begin
      for (int c = 0; c < REPORT_CH; c++) begin
         prod[c]    = PROD_W'(blk_sums[c]) * PROD_W'(RECIP);
         avgs_in[c] = prod[c][SHIFT +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else if (blk_ready) begin
         avg_valid_ff <= blk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         avgs_ff <= avgs_in;
      end
   end

   assign avg_valid = avg_valid_ff;
   assign avgs      = avgs_ff;

endmodule

// ----- sv/abta_judge.sv -----
// Threshold mask, battery conversion and low-battery flag, ending in the result register.
module abta_judge import abta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        avg_valid,
   output logic        avg_ready,
   input  avg_set_type avgs,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);

   logic                  s2_valid_ff;
   logic                  s2_ready;
   avg_set_type           s2_avgs_ff;
   logic [SENSORS-1:0]    s2_mask_ff, s2_mask_in;
   logic                  s2_low_ff, s2_low_in;
   logic [BAT_PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [BAT_PROD_W-1:0] limit;

   logic                  out_valid_ff;
   rsp_type               out_ff, out_in;
   logic [BAT_FULL_W-1:0] bat_full;

   assign s2_ready  = !out_valid_ff || rsp_ready;
   assign avg_ready = !s2_valid_ff || s2_ready;

   always_comb begin
      for (int i = 0; i < SENSORS; i++) begin
         s2_mask_in[i] = (THR_W'(avgs[i]) < cfg.threshold) && cfg.enable[i];
      end
      s2_prod_in = BAT_PROD_W'(avgs[BAT_CH]) * BAT_PROD_W'(BAT_SCALE_MV);
      // Millivolt limit times 4095, formed as a shift and a subtract.
      limit      = (BAT_PROD_W'(cfg.low_mv) << SAMPLE_W) - BAT_PROD_W'(cfg.low_mv);
      s2_low_in  = s2_prod_in <= limit;
   end

   always_comb begin
      bat_full               = BAT_FULL_W'(s2_prod_ff) * BAT_FULL_W'(BAT_RECIP);
      out_in.avg_left_side   = s2_avgs_ff[0];
      out_in.avg_left_front  = s2_avgs_ff[1];
      out_in.avg_right_front = s2_avgs_ff[2];
      out_in.avg_right_side  = s2_avgs_ff[3];
      out_in.seeing_mask     = s2_mask_ff;
      out_in.battery_mv      = bat_full[BAT_SHIFT +: MV_W];
      out_in.low_battery     = s2_low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (avg_ready) begin
            s2_valid_ff <= avg_valid;
         end
         if (s2_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (avg_valid && avg_ready) begin
         s2_avgs_ff <= avgs;
         s2_mask_ff <= s2_mask_in;
         s2_low_ff  <= s2_low_in;
         s2_prod_ff <= s2_prod_in;
      end
      if (s2_valid_ff && s2_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

// ----- sv/adc_block_average_threshold.sv -----
// Top level of the ADC block averaging and threshold block.
// Throughput: one sample transfer per cycle unless the input stalls; one result per CHANNELS * ROUNDS samples.
// The transfer of a block's last sample loads the block register; the average,
// decision and output registers follow.
// Input stalls only when a block's last sample finds all four result stages full and
// the result is not being taken.
// Reset (synchronous, active high) clears position, round count, sums and valid flags, and loads the register defaults.
module adc_block_average_threshold import abta_pkg::*; #(
   parameter int CHANNELS = 5,
   parameter int ROUNDS = 16
) (
   input logic       clock,
   input logic       reset,
   abta_req_if.sink  req_bus,
   abta_rsp_if.source rsp_bus,
   abta_csr_if.sink  csr_bus
);

   localparam int SUM_W = SAMPLE_W + $clog2(ROUNDS);

   // Configuration registers. Writes are accepted in every cycle; a write to an
   // index past the last register is dropped.
   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            CSR_SEEING_THRESHOLD: cfg_in.threshold = csr_bus.data[THR_W-1:0];
            CSR_SENSOR_ENABLE:    cfg_in.enable    = csr_bus.data[SENSORS-1:0];
            CSR_LOW_BATTERY_MV:   cfg_in.low_mv    = csr_bus.data[MV_W-1:0];
            default:              cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.enable    <= ENABLE_RESET;
         cfg_ff.low_mv    <= LOW_BAT_MV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accumulation: each sample transfer adds into the sum of its channel. The
   // last sample of the last round moves the completed sums into the block
   // register and clears the running sums in the same cycle.
   logic             blk_valid, blk_ready;
   logic [SUM_W-1:0] blk_sums [REPORT_CH];

   abta_accum #(
      .CHANNELS (CHANNELS),
      .ROUNDS   (ROUNDS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_sample (req_bus.sample),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_sums  (blk_sums)
   );

   // Averages: the sum divided by the round count through a constant reciprocal.
   logic        avg_valid, avg_ready;
   avg_set_type avgs;

   abta_average #(
      .ROUNDS (ROUNDS)
   ) u_average (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_sums  (blk_sums),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avgs      (avgs)
   );

   // Decision stage and output register: seeing mask, battery millivolts and
   // the low-battery flag, compared exactly as avg * 13300 against limit * 4095.
   rsp_type rsp;

   abta_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avgs      (avgs),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp       (rsp)
   );

   assign rsp_bus.avg_left_side   = rsp.avg_left_side;
   assign rsp_bus.avg_left_front  = rsp.avg_left_front;
   assign rsp_bus.avg_right_front = rsp.avg_right_front;
   assign rsp_bus.avg_right_side  = rsp.avg_right_side;
   assign rsp_bus.seeing_mask     = rsp.seeing_mask;
   assign rsp_bus.battery_mv      = rsp.battery_mv;
   assign rsp_bus.low_battery     = rsp.low_battery;

   // A sensor may only be reported as seeing when it is enabled.
   a_mask_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.seeing_mask & ~cfg_ff.enable) == '0)
      else $error("seeing mask reports a disabled sensor");

   // Every reported sensor lies below the threshold.
   a_mask_below: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (!rsp_bus.seeing_mask[0] || THR_W'(rsp_bus.avg_left_side) < cfg_ff.threshold) &&
         (!rsp_bus.seeing_mask[1] || THR_W'(rsp_bus.avg_left_front) < cfg_ff.threshold) &&
         (!rsp_bus.seeing_mask[2] || THR_W'(rsp_bus.avg_right_front) < cfg_ff.threshold) &&
         (!rsp_bus.seeing_mask[3] || THR_W'(rsp_bus.avg_right_side) < cfg_ff.threshold))
      else $error("seeing mask disagrees with threshold");

   // The low-battery flag and the converted voltage must tell the same story.
   a_low_battery: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (rsp_bus.low_battery ? (rsp_bus.battery_mv <= cfg_ff.low_mv)
                              : (rsp_bus.battery_mv >= cfg_ff.low_mv)))
      else $error("low battery flag disagrees with battery voltage");

endmodule

// ----- test/adc_block_average_threshold_tb.sv -----
// Self-checking testbench for the ADC block averaging and threshold block.
`timescale 1ns / 1ps

module adc_block_average_threshold_tb;
   import abta_pkg::*;

   // The block is built with its default channel count and block length, so one
   // report comes out for every CHANNELS * ROUNDS sample transfers.
   localparam int CHANNELS        = 5;
   localparam int ROUNDS          = 16;
   localparam int BLOCK_SAMPLES   = CHANNELS * ROUNDS;
   localparam int FULL_SCALE_CODE = 4095;

   // Register index that decodes to no register; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // The settle time after the last report covers a block still in flight.
   localparam int SETTLE_CYCLES  = 10;
   localparam int HOLD_CYCLES    = 600;
   localparam int RANDOM_ITEMS   = 800;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SHOWN_ERRORS   = 10;
   localparam int DIRECTED_ROWS  = 16;

   logic clock = 1'b0;
   logic reset;

   abta_req_if req_bus ();
   abta_rsp_if rsp_bus ();
   abta_csr_if csr_bus ();

   adc_block_average_threshold #(
      .CHANNELS(CHANNELS),
      .ROUNDS  (ROUNDS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state. It follows the sample and register transfers that the
   // monitor sees, so it stays in step with the block whatever the timing.
   // ------------------------------------------------------------------------
   cfg_type     live_regs;
   logic [31:0] sum_by_channel [CHANNELS];
   int          next_channel;
   int          rounds_done;

   rsp_type     pending_reports [$];
   int          mismatch_count = 0;
   int          report_count   = 0;
   int          cycle_count    = 0;

   // A directed row may carry a hand-written report. While this flag is set the
   // monitor queues that report in place of the predicted one.
   bit          directed_fixed_on = 1'b0;
   rsp_type     directed_fixed;

   // Traffic shaping, written by the main process only.
   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          hold_requests = 0;

   // Stimulus-side view of the stream and of the registers, used to aim the
   // random block levels at the seeing and low battery boundaries.
   int          samples_sent  = 0;
   int          cur_threshold = THRESHOLD_RESET;
   int          cur_low_mv    = LOW_BAT_MV_RESET;
   int          block_center [CHANNELS];
   int          block_spread [CHANNELS];

   // One directed row is one whole block: an optional register write ahead of
   // it, then ROUNDS rounds in which every channel repeats its level.
   typedef struct {
      bit                                 write_reg;
      logic [CSR_IDX_W-1:0]               reg_index;
      logic [CSR_DATA_W-1:0]              reg_data;
      logic [0:REPORT_CH-1][SAMPLE_W-1:0] levels;
      bit                                 fixed_result;
      rsp_type                            fixed;
   } block_row_type;

   // Report fields in order: left side, left front, right front, right side,
   // seeing mask, battery millivolts, low battery.
   block_row_type directed_rows [DIRECTED_ROWS] = '{
      // Reset registers, all channels at zero: everything sees, battery flat.
      '{1'b0, CSR_SEEING_THRESHOLD, 14'd0,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 4'hF, 14'd0, 1'b1}},
      // All channels at full scale: nothing sees, battery at its top value.
      '{1'b0, CSR_SEEING_THRESHOLD, 14'd0,
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
        1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'h0, 14'd13300, 1'b0}},
      // Averages on both sides of the threshold and of the low battery level.
      '{1'b0, CSR_SEEING_THRESHOLD, 14'd0,
        '{12'd999, 12'd1000, 12'd1001, 12'd0, 12'd3463},
        1'b0, '0},
      '{1'b0, CSR_SEEING_THRESHOLD, 14'd0,
        '{12'd1, 12'd2048, 12'd4094, 12'd3000, 12'd3464},
        1'b0, '0},
      // A write to the unused index must leave the reset registers in place.
      '{1'b1, CSR_UNUSED_INDEX, 14'h3FFF,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 4'hF, 14'd0, 1'b1}},
      // A threshold above full scale makes every enabled sensor see.
      '{1'b1, CSR_SEEING_THRESHOLD, 14'd4096,
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
        1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'hF, 14'd13300, 1'b0}},
      // Write data wider than the threshold register is cut to 13 bits.
      '{1'b1, CSR_SEEING_THRESHOLD, 14'h3FFF,
        '{12'd4095, 12'd0, 12'd2000, 12'd4000, 12'd100},
        1'b0, '0},
      // A zero threshold: no average is below it.
      '{1'b1, CSR_SEEING_THRESHOLD, 14'd0,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 4'h0, 14'd0, 1'b1}},
      // All sensors disabled, with the upper write bits set and dropped.
      '{1'b1, CSR_SENSOR_ENABLE, 14'h3FF0,
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
        1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'h0, 14'd13300, 1'b0}},
      '{1'b1, CSR_SEEING_THRESHOLD, 14'd4096,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 4'h0, 14'd0, 1'b1}},
      '{1'b1, CSR_SENSOR_ENABLE, 14'd5,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 4'h5, 14'd0, 1'b1}},
      '{1'b1, CSR_SENSOR_ENABLE, 14'd15,
        '{12'd10, 12'd20, 12'd30, 12'd40, 12'd50},
        1'b0, '0},
      // A zero low battery level still flags a battery reading of zero.
      '{1'b1, CSR_LOW_BATTERY_MV, 14'd0,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 4'hF, 14'd0, 1'b1}},
      '{1'b0, CSR_LOW_BATTERY_MV, 14'd0,
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd1},
        1'b0, '0},
      // The highest low battery level flags even a full-scale battery.
      '{1'b1, CSR_LOW_BATTERY_MV, 14'h3FFF,
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
        1'b1, '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'hF, 14'd13300, 1'b1}},
      '{1'b1, CSR_LOW_BATTERY_MV, 14'd11250,
        '{12'd500, 12'd1500, 12'd2500, 12'd3500, 12'd3464},
        1'b0, '0}
   };

   // Adds one sample to the running sums. On the last sample of a block it
   // fills in the report and returns 1, then clears the sums.
   function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] s,
                                            output rsp_type report);
      logic [SAMPLE_W-1:0] avg [SENSORS];
      logic [SAMPLE_W-1:0] bat_avg;
      logic [63:0]         bat_product;
      logic [63:0]         low_product;
      report = '0;
      sum_by_channel[next_channel] += s;
      if (next_channel + 1 < CHANNELS) begin
         next_channel++;
         return 1'b0;
      end
      next_channel = 0;
      rounds_done++;
      if (rounds_done < ROUNDS) begin
         return 1'b0;
      end
      rounds_done = 0;
      for (int i = 0; i < SENSORS; i++) begin
         avg[i] = SAMPLE_W'(sum_by_channel[i] / ROUNDS);
         if (avg[i] < live_regs.threshold && live_regs.enable[i]) begin
            report.seeing_mask[i] = 1'b1;
         end
      end
      report.avg_left_side   = avg[0];
      report.avg_left_front  = avg[1];
      report.avg_right_front = avg[2];
      report.avg_right_side  = avg[3];
      // Comparing the two products keeps the low battery test exact, without
      // the rounding of the millivolt value.
      bat_avg            = SAMPLE_W'(sum_by_channel[BAT_CH] / ROUNDS);
      bat_product        = 64'(bat_avg) * BAT_SCALE_MV;
      low_product        = 64'(live_regs.low_mv) * FULL_SCALE_CODE;
      report.battery_mv  = MV_W'(bat_product / FULL_SCALE_CODE);
      report.low_battery = (bat_product <= low_product);
      for (int i = 0; i < CHANNELS; i++) begin
         sum_by_channel[i] = '0;
      end
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS) begin
         $display("report %0d: %s expected %0d, got %0d", report_count, field, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge; stimulus moves at the
   // falling edge, so the order of events inside a time step cannot matter.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type want;
      rsp_type got;
      if (reset) begin
         live_regs    = '{THRESHOLD_RESET, ENABLE_RESET, LOW_BAT_MV_RESET};
         next_channel = 0;
         rounds_done  = 0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_by_channel[i] = '0;
         end
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               CSR_SEEING_THRESHOLD: live_regs.threshold = csr_bus.data[THR_W-1:0];
               CSR_SENSOR_ENABLE:    live_regs.enable = csr_bus.data[SENSORS-1:0];
               CSR_LOW_BATTERY_MV:   live_regs.low_mv = csr_bus.data[MV_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (accumulate_sample(req_bus.sample, predicted)) begin
               pending_reports.push_back(directed_fixed_on ? directed_fixed : predicted);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            report_count++;
            got = '{rsp_bus.avg_left_side, rsp_bus.avg_left_front, rsp_bus.avg_right_front,
                    rsp_bus.avg_right_side, rsp_bus.seeing_mask, rsp_bus.battery_mv,
                    rsp_bus.low_battery};
            if (pending_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_ERRORS) begin
                  $display("report %0d arrived with nothing outstanding", report_count);
               end
            end else begin
               want = pending_reports.pop_front();
               if (got.avg_left_side != want.avg_left_side) begin
                  note_mismatch("avg_left_side", want.avg_left_side, got.avg_left_side);
               end
               if (got.avg_left_front != want.avg_left_front) begin
                  note_mismatch("avg_left_front", want.avg_left_front, got.avg_left_front);
               end
               if (got.avg_right_front != want.avg_right_front) begin
                  note_mismatch("avg_right_front", want.avg_right_front,
                                got.avg_right_front);
               end
               if (got.avg_right_side != want.avg_right_side) begin
                  note_mismatch("avg_right_side", want.avg_right_side, got.avg_right_side);
               end
               if (got.seeing_mask != want.seeing_mask) begin
                  note_mismatch("seeing_mask", want.seeing_mask, got.seeing_mask);
               end
               if (got.battery_mv != want.battery_mv) begin
                  note_mismatch("battery_mv", want.battery_mv, got.battery_mv);
               end
               if (got.low_battery != want.low_battery) begin
                  note_mismatch("low_battery", want.low_battery, got.low_battery);
               end
            end
         end
      end
   end

   // The run is cut off well past the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver. It stalls at random at the current rate, and on request
   // holds ready low for a long stretch so that the pipeline fills up and the
   // block has to push back on the sample channel.
   // ------------------------------------------------------------------------
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen     = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus. Every task starts and ends at a falling edge. Valid is only
   // lowered when the sender goes idle, so a back-to-back transfer never sees
   // valid dropped and raised in the same time step.
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.data      <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_SEEING_THRESHOLD: cur_threshold = int'(value[THR_W-1:0]);
         CSR_LOW_BATTERY_MV:   cur_low_mv = int'(value);
         default: ;
      endcase
   endtask

   // Takes the sender off the channel, waits until every queued report has
   // been received, then lets the block settle for longer than its latency.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Random samples are shaped per block: each channel gets a level and a
   // spread at the start of a block, so that averages land on the extremes,
   // on the seeing threshold and on the low battery boundary, not only near
   // mid scale. A full-scale spread gives plain random samples.
   function automatic logic [SAMPLE_W-1:0] next_random_sample();
      int ch;
      int v;
      ch = samples_sent % CHANNELS;
      if (samples_sent % BLOCK_SAMPLES == 0) begin
         for (int c = 0; c < CHANNELS; c++) begin
            case ($urandom_range(5))
               0: block_center[c] = 0;
               1: block_center[c] = FULL_SCALE_CODE;
               2: block_center[c] = (c == BAT_CH) ?
                                    cur_low_mv * FULL_SCALE_CODE / BAT_SCALE_MV :
                                    cur_threshold;
               default: block_center[c] = int'($urandom_range(FULL_SCALE_CODE));
            endcase
            block_spread[c] = ($urandom_range(3) == 0) ? FULL_SCALE_CODE :
                              int'($urandom_range(8));
         end
      end
      v = block_center[ch] + int'($urandom_range(2 * block_spread[ch])) - block_spread[ch];
      if (v < 0) begin
         v = 0;
      end else if (v > FULL_SCALE_CODE) begin
         v = FULL_SCALE_CODE;
      end
      return SAMPLE_W'(v);
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] value;
      int phase;
      int phase_len;
      int random_items;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.sample    = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = CSR_SEEING_THRESHOLD;
      csr_bus.data      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: one block per row, no idling on either side. Rows with
      // an obvious result are checked against the result typed in the table.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         wait_idle();
         if (directed_rows[row].write_reg) begin
            write_register(directed_rows[row].reg_index, directed_rows[row].reg_data);
         end
         directed_fixed_on = directed_rows[row].fixed_result;
         directed_fixed    = directed_rows[row].fixed;
         for (int k = 0; k < BLOCK_SAMPLES; k++) begin
            send_sample(directed_rows[row].levels[k % CHANNELS]);
         end
      end
      wait_idle();
      directed_fixed_on = 1'b0;

      // Random part in phases. Each phase starts from an idle block with fresh
      // register values and one of four idling patterns. Phase lengths are
      // mostly not multiples of a block, so register writes also fall between
      // the rounds of a partly summed block.
      phase        = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(4))
            0: value = '0;
            1: value = 14'd4096;
            2: value = '1;
            3: value = 14'(THRESHOLD_RESET);
            default: value = 14'($urandom_range(16383));
         endcase
         write_register(CSR_SEEING_THRESHOLD, value);
         case ($urandom_range(3))
            0: value = '0;
            1: value = 14'(ENABLE_RESET);
            default: value = 14'($urandom_range(16383));
         endcase
         write_register(CSR_SENSOR_ENABLE, value);
         case ($urandom_range(4))
            0: value = '0;
            1: value = '1;
            2: value = LOW_BAT_MV_RESET;
            default: value = 14'($urandom_range(16383));
         endcase
         write_register(CSR_LOW_BATTERY_MV, value);
         if ($urandom_range(3) == 0) begin
            write_register(CSR_UNUSED_INDEX, 14'($urandom_range(16383)));
         end

         case (phase % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 55;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 55;
            end
            default: begin
               req_idle_pct  = 20;
               rsp_stall_pct = 20;
            end
         endcase

         // The first phase holds the receiver off long enough for every
         // result stage to fill, while samples keep coming at full rate.
         // Later in that phase the sender waits until all reports are in.
         phase_len = (phase == 0) ? 700 : int'($urandom_range(200, 600));
         if (phase == 0) begin
            hold_requests++;
         end
         for (int n = 0; n < phase_len; n++) begin
            if (phase == 0 && n == 600) begin
               wait_idle();
            end
            send_sample(next_random_sample());
            random_items++;
         end
         phase++;
      end

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      wait_idle();

      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- adc_block_average_threshold.f -----
sv/abta_pkg.sv
sv/abta_if.sv
sv/abta_accum.sv
sv/abta_average.sv
sv/abta_judge.sv
sv/adc_block_average_threshold.sv
test/adc_block_average_threshold_tb.sv
